>>> hw/rtl/aar_pkg.sv
// ----------------------------------------------------------------------------
// aar_pkg
// Shared widths, constants and types for the axis-angle rotation matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aar_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int OUT_FRAC_BITS = 14;

  localparam int ATAN_LEN   = 24;
  localparam int TRIG_STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  localparam int AW = 16;  // axis / angle
  localparam int CW = 34;  // Q3.30 working values
  localparam int UW = 32;  // unit axis components
  localparam int SW = 32;  // squared length
  localparam int QW = 32;  // square root
  localparam int RW = 36;  // root remainder
  localparam int IW = 47;  // reciprocal
  localparam int MW = 36;  // entry sums

  localparam int SQRT_STAGES = QW / 2;
  localparam int DIV_STAGES  = (IW + 1) / 2;
  localparam int SQRT_PAIRS  = SW / 4;
  localparam int NORM_REGS   = 1 + SQRT_STAGES + DIV_STAGES;
  localparam int LAT_NORM    = 2 + SQRT_STAGES + DIV_STAGES;
  localparam int LAT_TRIG    = 3 + TRIG_STEPS;
  localparam int TRIG_PAD    = LAT_NORM - LAT_TRIG;

  localparam logic signed [16:0] TURN_U    = 17'sd23040;
  localparam logic signed [16:0] HALF_U    = 17'sd11520;
  localparam logic signed [16:0] QUARTER_U = 17'sd5760;
  localparam logic signed [16:0] THREEQ_U  = 17'sd17280;

  localparam logic signed [19:0]   RAD_Q30  = 20'sd292818;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;

  localparam logic [QW-1:0] DIV_REM0 = QW'(64'd1 << (62 - IW));

  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  localparam int    OUT_SH  = 30 - OUT_FRAC_BITS;
  localparam longint OUT_ONE = 64'sd1 <<< OUT_FRAC_BITS;
  localparam logic signed [MW-1:0] OUT_RND =
    (OUT_SH > 0) ? (MW'(1) <<< (OUT_SH - 1)) : '0;
  localparam logic signed [MW-1:0] OUT_HI = MW'((OUT_ONE > 32767) ? 32767 : OUT_ONE);
  localparam logic signed [MW-1:0] OUT_LO = MW'((-OUT_ONE < -32768) ? -32768 : -OUT_ONE);

  typedef logic signed [AW-1:0] axis_t;
  typedef logic signed [CW-1:0] q30_t;
  typedef logic signed [UW-1:0] unit_t;
  typedef logic signed [15:0]   entry_t;

endpackage

>>> hw/rtl/aar_trig.sv
// ----------------------------------------------------------------------------
// aar_trig
// Angle reduction and fold, pipelined CORDIC (one rotation per stage),
// then c, s and t = 1 - c, delayed to line up with the axis normalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aar_trig (
  input  logic           clk_i,
  input  logic           en_i,
  input  aar_pkg::axis_t angle_i,
  output aar_pkg::q30_t  c_o,
  output aar_pkg::q30_t  s_o,
  output aar_pkg::q30_t  t_o
);
  import aar_pkg::*;

  logic signed [16:0] v1, v2, v3, fold_d;
  logic               flip_d;
  logic signed [16:0] fold_q;
  logic signed [36:0] zprod;

  logic flp_q [TRIG_STEPS+2];
  q30_t cx_q  [TRIG_STEPS+1];
  q30_t cy_q  [TRIG_STEPS+1];
  q30_t cz_q  [TRIG_STEPS+1];
  q30_t c_d, s_d;
  q30_t c_q   [TRIG_PAD+1];
  q30_t s_q   [TRIG_PAD+1];
  q30_t t_q   [TRIG_PAD+1];

  always_comb begin
    v1 = (17'(angle_i) >= TURN_U) ? 17'(angle_i) - TURN_U : 17'(angle_i);
    v2 = (v1 < 0) ? v1 + TURN_U : v1;
    v3 = (v2 < 0) ? v2 + TURN_U : v2;
    fold_d = v3;
    flip_d = 1'b0;
    if (v3 >= THREEQ_U) begin
      fold_d = v3 - TURN_U;
    end else if (v3 > QUARTER_U) begin
      fold_d = v3 - HALF_U;
      flip_d = 1'b1;
    end
  end

  assign zprod = fold_q * RAD_Q30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fold_q   <= fold_d;
      flp_q[0] <= flip_d;
      flp_q[1] <= flp_q[0];
      cx_q[0]  <= GAIN_Q30;
      cy_q[0]  <= '0;
      cz_q[0]  <= CW'(zprod);
    end
  end

  for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_step
    q30_t dx, dy, at;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;
    assign at = $signed(CW'(ATAN_Q30[i]));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cz_q[i][CW-1]) begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - at;
        end else begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + at;
        end
        flp_q[i+2] <= flp_q[i+1];
      end
    end
  end

  assign c_d = flp_q[TRIG_STEPS+1] ? -cx_q[TRIG_STEPS] : cx_q[TRIG_STEPS];
  assign s_d = flp_q[TRIG_STEPS+1] ? -cy_q[TRIG_STEPS] : cy_q[TRIG_STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q[0] <= c_d;
      s_q[0] <= s_d;
      t_q[0] <= ONE_Q30 - c_d;
    end
  end

  for (genvar k = 1; k <= TRIG_PAD; k++) begin : g_pad
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_q[k] <= c_q[k-1];
        s_q[k] <= s_q[k-1];
        t_q[k] <= t_q[k-1];
      end
    end
  end

  assign c_o = c_q[TRIG_PAD];
  assign s_o = s_q[TRIG_PAD];
  assign t_o = t_q[TRIG_PAD];

endmodule

>>> hw/rtl/aar_norm.sv
// ----------------------------------------------------------------------------
// aar_norm
// Axis normalizer: squared length, pipelined sqrt (two root bits a stage),
// pipelined reciprocal (two bits a stage, one in the last), unit components.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aar_norm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  aar_pkg::axis_t ax_i,
  input  aar_pkg::axis_t ay_i,
  input  aar_pkg::axis_t az_i,
  output logic           vld_o,
  output logic           zero_o,
  output aar_pkg::unit_t ux_o,
  output aar_pkg::unit_t uy_o,
  output aar_pkg::unit_t uz_o
);
  import aar_pkg::*;

  typedef struct packed {
    logic  zero;
    axis_t ax;
    axis_t ay;
    axis_t az;
  } side_t;

  typedef struct packed {
    logic [QW-1:0] root;
    logic [RW-1:0] rem;
  } sqst_t;

  typedef struct packed {
    logic [IW-1:0] quo;
    logic [QW-1:0] rem;
  } dvst_t;

  function automatic sqst_t sq_step(sqst_t a, logic [1:0] pair);
    logic [RW-1:0] r2, tr;
    sqst_t o;
    r2 = {a.rem[RW-3:0], pair};
    tr = RW'({a.root, 2'b01});
    if (r2 >= tr) begin
      o.rem  = r2 - tr;
      o.root = {a.root[QW-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {a.root[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dvst_t dv_step(dvst_t a, logic [QW-1:0] den);
    logic [QW:0] r2;
    dvst_t o;
    r2 = {a.rem, 1'b0};
    if (r2 >= {1'b0, den}) begin
      o.rem = QW'(r2 - {1'b0, den});
      o.quo = {a.quo[IW-2:0], 1'b1};
    end else begin
      o.rem = QW'(r2);
      o.quo = {a.quo[IW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic unit_t unit_comp(axis_t a, logic [IW-1:0] inv);
    logic [AW-1:0]    mag;
    logic [AW+IW-1:0] p;
    logic [UW-1:0]    u;
    mag = a[AW-1] ? AW'(-a) : AW'(a);
    p   = (AW+IW)'(mag) * (AW+IW)'(inv);
    u   = p[16 +: UW];
    return a[AW-1] ? -u : u;
  endfunction

  logic signed [31:0] pxx, pyy, pzz;
  logic [SW-1:0]      ssq_d;

  side_t         side_q [NORM_REGS];
  logic          vld_q  [NORM_REGS];
  logic [SW-1:0] ssq_q  [SQRT_PAIRS];
  sqst_t         sq_q   [SQRT_STAGES+1];
  dvst_t         dv_q   [DIV_STAGES];
  logic [QW-1:0] den_q  [DIV_STAGES];

  assign pxx   = ax_i * ax_i;
  assign pyy   = ay_i * ay_i;
  assign pzz   = az_i * az_i;
  assign ssq_d = $unsigned(pxx) + $unsigned(pyy) + $unsigned(pzz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= '{zero: (ssq_d == '0), ax: ax_i, ay: ay_i, az: az_i};
      ssq_q[0]  <= ssq_d;
      sq_q[0]   <= '0;
    end
  end

  for (genvar k = 1; k < NORM_REGS; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    logic [1:0] p0, p1;
    sqst_t      a1;
    if (j < SQRT_PAIRS) begin : g_bits
      assign p0 = ssq_q[j][SW-1-4*j -: 2];
      assign p1 = ssq_q[j][SW-3-4*j -: 2];
    end else begin : g_zero
      assign p0 = '0;
      assign p1 = '0;
    end
    if (j + 1 < SQRT_PAIRS) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ssq_q[j+1] <= ssq_q[j];
        end
      end
    end
    assign a1 = sq_step(sq_q[j], p0);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[j+1] <= sq_step(a1, p1);
      end
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    dvst_t         din, a1, a2;
    logic [QW-1:0] den;
    if (j == 0) begin : g_first
      assign den = sq_q[SQRT_STAGES].root;
      assign din = '{quo: '0, rem: DIV_REM0};
    end else begin : g_next
      assign den = den_q[j-1];
      assign din = dv_q[j-1];
    end
    assign a1 = dv_step(din, den);
    if (2 * j + 1 < IW) begin : g_two
      assign a2 = dv_step(a1, den);
    end else begin : g_one
      assign a2 = a1;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[j]  <= a2;
        den_q[j] <= den;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_q[NORM_REGS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_o <= side_q[NORM_REGS-1].zero;
      ux_o   <= unit_comp(side_q[NORM_REGS-1].ax, dv_q[DIV_STAGES-1].quo);
      uy_o   <= unit_comp(side_q[NORM_REGS-1].ay, dv_q[DIV_STAGES-1].quo);
      uz_o   <= unit_comp(side_q[NORM_REGS-1].az, dv_q[DIV_STAGES-1].quo);
    end
  end

endmodule

>>> hw/rtl/aar_matrix.sv
// ----------------------------------------------------------------------------
// aar_matrix
// Rodrigues entries in three stages: axis and sine products, products with
// t, then sums, rounding and saturation into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aar_matrix (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic            zero_i,
  input  aar_pkg::unit_t  ux_i,
  input  aar_pkg::unit_t  uy_i,
  input  aar_pkg::unit_t  uz_i,
  input  aar_pkg::q30_t   c_i,
  input  aar_pkg::q30_t   s_i,
  input  aar_pkg::q30_t   t_i,
  output logic            vld_o,
  output logic            zero_o,
  output aar_pkg::entry_t m_o [9]
);
  import aar_pkg::*;

  function automatic q30_t qmul(q30_t a, q30_t b);
    logic signed [2*CW-1:0] p;
    p = a * b;
    return CW'(p >>> 30);
  endfunction

  function automatic entry_t to_out(logic signed [MW-1:0] v);
    logic signed [MW-1:0] r;
    r = (v + OUT_RND) >>> OUT_SH;
    if (r > OUT_HI) begin
      r = OUT_HI;
    end else if (r < OUT_LO) begin
      r = OUT_LO;
    end
    return r[15:0];
  endfunction

  q30_t x, y, z;
  q30_t pr1_q [9];
  q30_t c1_q, t1_q, c2_q;
  q30_t tp2_q [6];
  q30_t sp2_q [3];
  logic zero1_q, zero2_q, vld1_q, vld2_q;
  logic signed [MW-1:0] m_d [9];

  assign x = CW'(ux_i);
  assign y = CW'(uy_i);
  assign z = CW'(uz_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld_o  <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld_o  <= vld2_q;
    end
  end

  // xx yy zz xy xz yz sx sy sz
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr1_q[0] <= qmul(x, x);
      pr1_q[1] <= qmul(y, y);
      pr1_q[2] <= qmul(z, z);
      pr1_q[3] <= qmul(x, y);
      pr1_q[4] <= qmul(x, z);
      pr1_q[5] <= qmul(y, z);
      pr1_q[6] <= qmul(s_i, x);
      pr1_q[7] <= qmul(s_i, y);
      pr1_q[8] <= qmul(s_i, z);
      c1_q     <= c_i;
      t1_q     <= t_i;
      zero1_q  <= zero_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) begin
        tp2_q[k] <= qmul(t1_q, pr1_q[k]);
      end
      for (int k = 0; k < 3; k++) begin
        sp2_q[k] <= pr1_q[6+k];
      end
      c2_q    <= c1_q;
      zero2_q <= zero1_q;
    end
  end

  always_comb begin
    m_d[0] = MW'(tp2_q[0]) + MW'(c2_q);
    m_d[4] = MW'(tp2_q[1]) + MW'(c2_q);
    m_d[8] = MW'(tp2_q[2]) + MW'(c2_q);
    m_d[1] = MW'(tp2_q[3]) + MW'(sp2_q[2]);
    m_d[3] = MW'(tp2_q[3]) - MW'(sp2_q[2]);
    m_d[2] = MW'(tp2_q[4]) - MW'(sp2_q[1]);
    m_d[6] = MW'(tp2_q[4]) + MW'(sp2_q[1]);
    m_d[5] = MW'(tp2_q[5]) + MW'(sp2_q[0]);
    m_d[7] = MW'(tp2_q[5]) - MW'(sp2_q[0]);
    if (zero2_q) begin
      for (int k = 0; k < 9; k++) begin
        m_d[k] = (k % 4 == 0) ? MW'(ONE_Q30) : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        m_o[k] <= to_out(m_d[k]);
      end
      zero_o <= zero2_q;
    end
  end

endmodule

>>> hw/rtl/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Axis-angle to 3x3 rotation matrix (Rodrigues), Q1.14 entries.
// Throughput: one item per cycle unless stalled; the longest chain is the 24-stage
// reciprocal after the 16-stage square root, which the CORDIC is padded to.
// An output stall while the output is valid holds the whole pipeline in place.
// Reset clears only the valid bits; the pipeline is empty after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_angle_rotation_matrix (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  aar_pkg::axis_t  axis_x_i,
  input  aar_pkg::axis_t  axis_y_i,
  input  aar_pkg::axis_t  axis_z_i,
  input  aar_pkg::axis_t  angle_deg_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output aar_pkg::entry_t r00_o,
  output aar_pkg::entry_t r01_o,
  output aar_pkg::entry_t r02_o,
  output aar_pkg::entry_t r10_o,
  output aar_pkg::entry_t r11_o,
  output aar_pkg::entry_t r12_o,
  output aar_pkg::entry_t r20_o,
  output aar_pkg::entry_t r21_o,
  output aar_pkg::entry_t r22_o,
  output logic            zero_axis_o
);
  import aar_pkg::*;

  logic   en;
  logic   n_vld, n_zero;
  unit_t  ux, uy, uz;
  q30_t   c, s, t;
  entry_t m [9];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  aar_trig u_trig (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (angle_deg_i),
    .c_o     (c),
    .s_o     (s),
    .t_o     (t)
  );

  aar_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .ax_i   (axis_x_i),
    .ay_i   (axis_y_i),
    .az_i   (axis_z_i),
    .vld_o  (n_vld),
    .zero_o (n_zero),
    .ux_o   (ux),
    .uy_o   (uy),
    .uz_o   (uz)
  );

  aar_matrix u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (n_vld),
    .zero_i (n_zero),
    .ux_i   (ux),
    .uy_i   (uy),
    .uz_i   (uz),
    .c_i    (c),
    .s_i    (s),
    .t_i    (t),
    .vld_o  (out_valid_o),
    .zero_o (zero_axis_o),
    .m_o    (m)
  );

  assign r00_o = m[0];
  assign r01_o = m[1];
  assign r02_o = m[2];
  assign r10_o = m[3];
  assign r11_o = m[4];
  assign r12_o = m[5];
  assign r20_o = m[6];
  assign r21_o = m[7];
  assign r22_o = m[8];

endmodule
